### sv/lcdsbr_pkg.sv
package lcdsbr_pkg;

   localparam int CHAR_W          = 8;
   localparam int POS_W           = 4;
   localparam int LINE_LEN        = 16;
   localparam int ROWS            = 2;
   localparam int MEM_DEPTH       = ROWS * LINE_LEN;
   localparam int MEM_AW          = $clog2(MEM_DEPTH);
   localparam int REQ_TDATA_W     = 16;
   localparam int COLUMNS_DEFAULT = 16;

   localparam logic [CHAR_W-1:0] SET_ADDR_CMD = 8'h80;
   localparam logic [CHAR_W-1:0] ROW_OFFSET   = 8'h40;
   localparam logic [POS_W-1:0]  POS_MASK     = 4'hf;

   localparam int PROG_LEN = 9;
   localparam int STEP_W   = $clog2(PROG_LEN);

   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_FETCH         = STEP_W'(0);
   localparam step_type STEP_R0_CHECK      = STEP_W'(1);
   localparam step_type STEP_R0_ADDR_CHECK = STEP_W'(2);
   localparam step_type STEP_R0_CMD        = STEP_W'(3);
   localparam step_type STEP_R0_CHAR       = STEP_W'(4);
   localparam step_type STEP_R1_CHECK      = STEP_W'(5);
   localparam step_type STEP_R1_ADDR_CHECK = STEP_W'(6);
   localparam step_type STEP_R1_CMD        = STEP_W'(7);
   localparam step_type STEP_R1_CHAR       = STEP_W'(8);

   typedef enum logic [1:0] {
      EMIT_NONE,
      EMIT_CMD,
      EMIT_CHAR
   } emit_type;

   typedef enum logic [2:0] {
      COND_NONE,
      COND_ALWAYS,
      COND_NO_TICK,
      COND_CLEAN,
      COND_NO_ADDR
   } cond_type;

   typedef struct packed {
      logic     accept;
      emit_type emit;
      logic     row;
      cond_type cond;
      step_type target;
   } ucode_type;

   typedef struct packed {
      emit_type emit;
      logic     row;
      logic     wr_en;
   } ctrl_type;

   typedef struct packed {
      logic [ROWS-1:0] dirty;
      logic [ROWS-1:0] need_addr;
      logic            out_free;
   } status_type;

endpackage

### sv/lcdsbr_rom.sv
module lcdsbr_rom
   import lcdsbr_pkg::*;
(
   input  step_type  step,
   output ucode_type word
);

   always_comb begin
      unique case (step)
         STEP_FETCH:
            word = '{accept: 1'b1, emit: EMIT_NONE, row: 1'b0,
                     cond: COND_NO_TICK, target: STEP_FETCH};
         STEP_R0_CHECK:
            word = '{accept: 1'b0, emit: EMIT_NONE, row: 1'b0,
                     cond: COND_CLEAN, target: STEP_R1_CHECK};
         STEP_R0_ADDR_CHECK:
            word = '{accept: 1'b0, emit: EMIT_NONE, row: 1'b0,
                     cond: COND_NO_ADDR, target: STEP_R0_CHAR};
         STEP_R0_CMD:
            word = '{accept: 1'b0, emit: EMIT_CMD, row: 1'b0,
                     cond: COND_NONE, target: STEP_FETCH};
         STEP_R0_CHAR:
            word = '{accept: 1'b0, emit: EMIT_CHAR, row: 1'b0,
                     cond: COND_NONE, target: STEP_FETCH};
         STEP_R1_CHECK:
            word = '{accept: 1'b0, emit: EMIT_NONE, row: 1'b1,
                     cond: COND_CLEAN, target: STEP_FETCH};
         STEP_R1_ADDR_CHECK:
            word = '{accept: 1'b0, emit: EMIT_NONE, row: 1'b1,
                     cond: COND_NO_ADDR, target: STEP_R1_CHAR};
         STEP_R1_CMD:
            word = '{accept: 1'b0, emit: EMIT_CMD, row: 1'b1,
                     cond: COND_NONE, target: STEP_FETCH};
         STEP_R1_CHAR:
            word = '{accept: 1'b0, emit: EMIT_CHAR, row: 1'b1,
                     cond: COND_ALWAYS, target: STEP_FETCH};
         default:
            word = '{accept: 1'b0, emit: EMIT_NONE, row: 1'b0,
                     cond: COND_ALWAYS, target: STEP_FETCH};
      endcase
   end

endmodule

### sv/lcdsbr_seq.sv
module lcdsbr_seq
   import lcdsbr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tuser,
   output logic       req_tready,
   input  status_type status,
   output ctrl_type   ctrl
);

   step_type  step_ff;
   step_type  step_in;
   ucode_type word;
   logic      stall;
   logic      taken;

   lcdsbr_rom u_rom (
      .step (step_ff),
      .word (word)
   );

   always_comb begin
      stall = (word.emit != EMIT_NONE) && !status.out_free;
      unique case (word.cond)
         COND_NONE:    taken = 1'b0;
         COND_ALWAYS:  taken = 1'b1;
         COND_NO_TICK: taken = !(req_tvalid && req_tuser);
         COND_CLEAN:   taken = !status.dirty[word.row];
         COND_NO_ADDR: taken = !status.need_addr[word.row];
         default:      taken = 1'b1;
      endcase
   end

   always_comb begin
      priority if (stall) begin
         step_in = step_ff;
      end else if (taken) begin
         step_in = word.target;
      end else begin
         step_in = STEP_W'(step_ff + 1'b1);
      end
   end

   always_comb begin
      req_tready = word.accept;
      ctrl.emit  = stall ? EMIT_NONE : word.emit;
      ctrl.row   = word.row;
      ctrl.wr_en = word.accept && req_tvalid && !req_tuser;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_FETCH;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

### sv/lcdsbr_dp.sv
module lcdsbr_dp
   import lcdsbr_pkg::*;
#(
   parameter int COLUMNS = COLUMNS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  ctrl_type          ctrl,
   input  logic              wr_row,
   input  logic [POS_W-1:0]  wr_column,
   input  logic [CHAR_W-1:0] wr_char,
   input  logic              wr_end,
   input  logic              rsp_tready,
   output logic              rsp_tvalid,
   output logic [CHAR_W-1:0] rsp_byte,
   output logic              rsp_is_data,
   output logic              rsp_last,
   output status_type        status
);

   localparam int CNT_W = $clog2(COLUMNS + 1);

   logic [CHAR_W-1:0] char_mem_ff [MEM_DEPTH];
   logic [POS_W-1:0]  pos_ff [ROWS];
   logic [POS_W-1:0]  pos_in [ROWS];
   logic [CNT_W-1:0]  cnt_ff [ROWS];
   logic [CNT_W-1:0]  cnt_in [ROWS];
   logic [ROWS-1:0]   dirty_ff;
   logic [ROWS-1:0]   dirty_in;
   logic              shown_ff;
   logic              shown_in;
   logic              valid_ff;
   logic              valid_in;
   logic [CHAR_W-1:0] byte_ff;
   logic [CHAR_W-1:0] byte_in;
   logic              data_ff;
   logic              data_in;
   logic              last_ff;
   logic              last_in;
   logic [POS_W-1:0]  sel_pos;
   logic [CHAR_W-1:0] cmd_byte;
   logic [MEM_AW-1:0] rd_addr;
   logic [MEM_AW-1:0] wr_addr;

   always_comb begin
      sel_pos  = pos_ff[ctrl.row] & POS_MASK;
      rd_addr  = {ctrl.row, sel_pos};
      wr_addr  = {wr_row, wr_column};
      cmd_byte = SET_ADDR_CMD | (ctrl.row ? ROW_OFFSET : '0)
               | {{(CHAR_W-POS_W){1'b0}}, sel_pos};
      for (int r = 0; r < ROWS; r++) begin
         status.need_addr[r] = (1'(r) != shown_ff) || (pos_ff[r] == '0);
      end
      status.dirty    = dirty_ff;
      status.out_free = !valid_ff || rsp_tready;
   end

   always_comb begin
      pos_in   = pos_ff;
      cnt_in   = cnt_ff;
      dirty_in = dirty_ff;
      shown_in = shown_ff;
      valid_in = valid_ff && !rsp_tready;
      byte_in  = byte_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      if (ctrl.wr_en && wr_end) begin
         dirty_in[wr_row] = 1'b1;
         cnt_in[wr_row]   = '0;
      end
      unique case (ctrl.emit)
         EMIT_CMD: begin
            valid_in = 1'b1;
            byte_in  = cmd_byte;
            data_in  = 1'b0;
            last_in  = 1'b0;
            shown_in = ctrl.row;
         end
         EMIT_CHAR: begin
            valid_in         = 1'b1;
            byte_in          = char_mem_ff[rd_addr];
            data_in          = 1'b1;
            last_in          = ctrl.row || !dirty_ff[1];
            pos_in[ctrl.row] = POS_W'(sel_pos + 1'b1);
            if (cnt_ff[ctrl.row] == CNT_W'(COLUMNS - 1)) begin
               cnt_in[ctrl.row]   = '0;
               dirty_in[ctrl.row] = 1'b0;
            end else begin
               cnt_in[ctrl.row] = CNT_W'(cnt_ff[ctrl.row] + 1'b1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MEM_DEPTH; i++) begin
            char_mem_ff[i] <= '0;
         end
      end else if (ctrl.wr_en) begin
         char_mem_ff[wr_addr] <= wr_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < ROWS; r++) begin
            pos_ff[r] <= '0;
            cnt_ff[r] <= '0;
         end
         dirty_ff <= '0;
         shown_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         cnt_ff   <= cnt_in;
         dirty_ff <= dirty_in;
         shown_ff <= shown_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid  = valid_ff;
   assign rsp_byte    = byte_ff;
   assign rsp_is_data = data_ff;
   assign rsp_last    = last_ff;

endmodule

### sv/lcd_shadow_buffer_refresher.sv
// Shadow buffer refresher for a two-row, sixteen-column character display.
// Request channel (req_): tuser selects the kind, 0 stores one character at
// row and column, 1 is a refresh tick; tlast on a store marks the row dirty
// and restarts its sent count. Response channel (rsp_): one byte per
// response, tuser high for character data and low for a set-address command,
// tlast high on the final response of a tick.
// A small control-store program, one step per cycle, runs each request.
// A store is written in the fetch step. A tick checks each row in turn and,
// for a dirty row, sends a set-address command when one is needed and then
// one character; its responses are registered and it gives at most 4
// responses. One request is handled at a time.
// While the receiver stalls with a response held, the program holds on its
// next output step; req_tready stays low until the tick is finished.
// Reset clears the buffer to zero, all rows clean, positions to zero, the
// last shown row to the upper row and the response register to empty.
module lcd_shadow_buffer_refresher
   import lcdsbr_pkg::*;
#(
   parameter int COLUMNS = COLUMNS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // row, column[3:0], char_byte[7:0], zero pad
   input  logic                   req_tuser,  // req_type
   input  logic                   req_tlast,  // end_of_write
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [CHAR_W-1:0]      rsp_tdata,  // out_byte[7:0]
   output logic                   rsp_tuser,  // is_data
   output logic                   rsp_tlast   // last
);

   ctrl_type   ctrl;
   status_type status;

   lcdsbr_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .ctrl       (ctrl)
   );

   lcdsbr_dp #(
      .COLUMNS (COLUMNS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .wr_row      (req_tdata[0]),
      .wr_column   (req_tdata[POS_W:1]),
      .wr_char     (req_tdata[POS_W+CHAR_W:POS_W+1]),
      .wr_end      (req_tlast),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_byte    (rsp_tdata),
      .rsp_is_data (rsp_tuser),
      .rsp_last    (rsp_tlast),
      .status      (status)
   );

endmodule
